// File: hw/rtl/opp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometer path pose package
// Shared widths, fixed-point constants, the CORDIC arctangent table and the
// pipeline depth of the pose unit.
// ----------------------------------------------------------------------------
package opp_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int COORD_BITS_DEF   = 20;

  // Fixed internal widths.
  localparam int PW    = 46;  // Bezier points, 44 significant bits
  localparam int PRW   = 64;  // lerp products
  localparam int NW    = 48;  // heading vector before normalization
  localparam int CW    = 44;  // CORDIC x and y
  localparam int ANG_W = 30;  // angles, degrees in Q.20
  localparam int NUMW  = 42;  // divider remainder
  localparam int DW    = 36;  // divider denominator
  localparam int QW    = 32;  // divider quotient bits, one per stage

  localparam logic signed [ANG_W-1:0] ANG_180  = 30'sd188743680;
  localparam logic signed [ANG_W-1:0] ANG_90   = 30'sd94371840;
  localparam logic signed [ANG_W-1:0] HEAD_MAX = 30'sd23040;
  localparam logic signed [31:0]      INV_GAIN = 32'sd652032874;

  typedef logic signed [PW-1:0]  pt_t;
  typedef logic signed [PRW-1:0] pr_t;

  function automatic logic signed [ANG_W-1:0] atan_ang(input int idx);
    logic signed [ANG_W-1:0] a;
    unique case (idx)
      0:       a = 30'sd47185920;
      1:       a = 30'sd27855475;
      2:       a = 30'sd14718068;
      3:       a = 30'sd7471121;
      4:       a = 30'sd3750058;
      5:       a = 30'sd1876857;
      6:       a = 30'sd938658;
      7:       a = 30'sd469357;
      8:       a = 30'sd234682;
      9:       a = 30'sd117342;
      10:      a = 30'sd58671;
      11:      a = 30'sd29335;
      12:      a = 30'sd14668;
      13:      a = 30'sd7334;
      14:      a = 30'sd3667;
      15:      a = 30'sd1833;
      16:      a = 30'sd917;
      17:      a = 30'sd458;
      18:      a = 30'sd229;
      19:      a = 30'sd115;
      20:      a = 30'sd57;
      21:      a = 30'sd29;
      22:      a = 30'sd14;
      23:      a = 30'sd7;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Index of the last pipeline register for a given CORDIC step count.
  function automatic int pipe_last(input int steps);
    return QW + 29 + 2 * steps;
  endfunction

endpackage

// File: hw/rtl/odometer_path_pose_unit.sv
`timescale 1ns / 1ps
// Throughput: one beat per cycle; busy is always low and nothing stalls.
// The 32-stage restoring divider and the two CORDIC chains set the depth.
// Reset is synchronous and clears the valid bits of every pipeline stage.
// ----------------------------------------------------------------------------
// Odometer path pose unit
// Position and heading on a straight or cubic Bezier path segment, computed
// by a fully pipelined divider, de Casteljau lerps and CORDIC chains.
// ----------------------------------------------------------------------------
module odometer_path_pose_unit #(
  parameter int CORDIC_STEPS = opp_pkg::CORDIC_STEPS_DEF,
  parameter int COORD_BITS   = opp_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [23:0]           travelled,
  input  logic                         is_straight,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic signed [COORD_BITS-1:0] ctrl1_x,
  input  logic signed [COORD_BITS-1:0] ctrl1_y,
  input  logic signed [COORD_BITS-1:0] ctrl2_x,
  input  logic signed [COORD_BITS-1:0] ctrl2_y,
  input  logic [19:0]                  seg_length,
  input  logic [15:0]                  counts_per_unit,
  output logic                         done,
  output logic                         valid_res,
  output logic signed [27:0]           pos_x,
  output logic signed [27:0]           pos_y,
  output logic signed [15:0]           heading
);

  localparam int CB   = COORD_BITS;
  localparam int F    = 44 - COORD_BITS;
  localparam int PW   = opp_pkg::PW;
  localparam int NW   = opp_pkg::NW;
  localparam int CW   = opp_pkg::CW;
  localparam int AW   = opp_pkg::ANG_W;
  localparam int NUMW = opp_pkg::NUMW;
  localparam int DW   = opp_pkg::DW;
  localparam int QW   = opp_pkg::QW;

  localparam int D_END = 2 + QW;
  localparam int B0    = D_END + 3;
  localparam int P_ST  = B0 + 10;
  localparam int M_ST  = P_ST + 1;
  localparam int V0    = M_ST + 11;
  localparam int H_ST  = V0 + CORDIC_STEPS + 1;
  localparam int LAST  = opp_pkg::pipe_last(CORDIC_STEPS);

  localparam opp_pkg::pt_t PT_RND  = opp_pkg::pt_t'(1) <<< (F - 9);
  localparam opp_pkg::pt_t POS_MAX = opp_pkg::pt_t'(134217727);
  localparam opp_pkg::pt_t POS_MIN = -opp_pkg::pt_t'(134217728);

  typedef struct packed {
    logic                         vld;
    logic                         ok;
    logic                         bad;
    logic                         straight;
    logic                         zero_vec;
    logic signed [23:0]           trav;
    logic signed [CB-1:0]         sx;
    logic signed [CB-1:0]         sy;
    logic signed [CB-1:0]         ex;
    logic signed [CB-1:0]         ey;
    logic signed [CB-1:0]         c1x;
    logic signed [CB-1:0]         c1y;
    logic signed [CB-1:0]         c2x;
    logic signed [CB-1:0]         c2y;
    logic [19:0]                  len;
    logic [15:0]                  rate;
    logic [DW-1:0]                dvs;
    logic [NUMW-1:0]              rem;
    logic [QW-1:0]                quo;
    logic [16:0]                  t;
    logic signed [32:0]           span;
    logic signed [63:0]           lprod;
    logic signed [CW-1:0]         l16;
    opp_pkg::pt_t [3:0]           ptx;
    opp_pkg::pt_t [3:0]           pty;
    opp_pkg::pt_t [2:0]           dfx;
    opp_pkg::pt_t [2:0]           dfy;
    opp_pkg::pr_t [2:0]           prx;
    opp_pkg::pr_t [2:0]           pry;
    logic signed [NW-1:0]         vx;
    logic signed [NW-1:0]         vy;
    logic [NW-1:0]                m;
    logic signed [CW-1:0]         cx;
    logic signed [CW-1:0]         cy;
    logic signed [AW-1:0]         cz;
    logic signed [15:0]           hd;
    opp_pkg::pt_t                 pos_x;
    opp_pkg::pt_t                 pos_y;
  } item_t;

  item_t pipe [0:LAST];
  item_t nxt  [0:LAST];
  item_t in_item;

  function automatic opp_pkg::pt_t ext_pt(input logic signed [CB-1:0] v);
    opp_pkg::pt_t r;
    r = {{(PW-CB){v[CB-1]}}, v};
    return r;
  endfunction

  function automatic logic signed [NW-1:0] ext_nw(input logic signed [CB-1:0] v);
    logic signed [NW-1:0] r;
    r = {{(NW-CB){v[CB-1]}}, v};
    return r;
  endfunction

  function automatic item_t f_clr(input item_t s);
    item_t r;
    r = s;
    r.vld = 1'b0;
    return r;
  endfunction

  function automatic item_t f_den(input item_t s);
    item_t r;
    r = s;
    r.dvs = DW'(s.len) * DW'(s.rate);
    r.bad = (s.rate == '0) || (s.len == '0) || (s.trav == '0);
    return r;
  endfunction

  function automatic item_t f_prep(input item_t s);
    item_t r;
    logic signed [24:0] tw;
    logic [24:0] at;
    logic beyond;
    r = s;
    tw = 25'(s.trav);
    at = (tw < 0) ? 25'(-tw) : 25'(tw);
    beyond = $signed({{13{s.trav[23]}}, s.trav}) > $signed({1'b0, s.dvs});
    r.ok = !s.bad && !beyond;
    r.quo = '0;
    if (s.straight) begin
      r.dvs = DW'(s.rate);
      r.rem = (NUMW'(at[23:0]) << 8) + NUMW'(s.rate >> 1);
    end else if (s.trav > 0) begin
      r.rem = (NUMW'(s.trav[22:0]) << 16) + NUMW'(s.dvs >> 1);
    end else begin
      r.rem = '0;
    end
    r.ptx[0] = ext_pt(s.sx) <<< F;
    r.pty[0] = ext_pt(s.sy) <<< F;
    r.ptx[1] = ext_pt(s.c1x) <<< F;
    r.pty[1] = ext_pt(s.c1y) <<< F;
    r.ptx[2] = ext_pt(s.c2x) <<< F;
    r.pty[2] = ext_pt(s.c2y) <<< F;
    r.ptx[3] = ext_pt(s.ex) <<< F;
    r.pty[3] = ext_pt(s.ey) <<< F;
    r.vx = ext_nw(s.ex) - ext_nw(s.sx);
    r.vy = ext_nw(s.ey) - ext_nw(s.sy);
    return r;
  endfunction

  function automatic item_t f_div(input item_t s, input int b);
    item_t r;
    logic [NUMW-1:0] d;
    r = s;
    d = NUMW'(s.dvs);
    if ((s.rem >> b) >= d) begin
      r.rem = s.rem - (d << b);
      r.quo[b] = 1'b1;
    end
    return r;
  endfunction

  function automatic item_t f_tsel(input item_t s);
    item_t r;
    r = s;
    r.t = (s.quo > QW'(65536)) ? 17'd65536 : s.quo[16:0];
    r.span = s.trav[23] ? -$signed({1'b0, s.quo}) : $signed({1'b0, s.quo});
    return r;
  endfunction

  function automatic item_t f_gain(input item_t s);
    item_t r;
    r = s;
    r.lprod = s.span * opp_pkg::INV_GAIN;
    return r;
  endfunction

  function automatic item_t f_l16(input item_t s);
    item_t r;
    r = s;
    r.l16 = CW'((s.lprod + 64'sd2097152) >>> 22);
    return r;
  endfunction

  function automatic item_t f_bsub(input item_t s, input logic last);
    item_t r;
    r = s;
    for (int i = 0; i < 3; i++) begin
      r.dfx[i] = $signed(s.ptx[i+1]) - $signed(s.ptx[i]);
      r.dfy[i] = $signed(s.pty[i+1]) - $signed(s.pty[i]);
    end
    if (last && !s.straight) begin
      r.vx = NW'($signed(r.dfx[0]));
      r.vy = NW'($signed(r.dfy[0]));
    end
    return r;
  endfunction

  function automatic item_t f_bmul(input item_t s);
    item_t r;
    r = s;
    for (int i = 0; i < 3; i++) begin
      r.prx[i] = $signed(s.dfx[i]) * $signed({1'b0, s.t});
      r.pry[i] = $signed(s.dfy[i]) * $signed({1'b0, s.t});
    end
    return r;
  endfunction

  function automatic item_t f_badd(input item_t s);
    item_t r;
    opp_pkg::pt_t tx;
    opp_pkg::pt_t ty;
    r = s;
    for (int i = 0; i < 3; i++) begin
      tx = PW'(($signed(s.prx[i]) + 64'sd32768) >>> 16);
      ty = PW'(($signed(s.pry[i]) + 64'sd32768) >>> 16);
      r.ptx[i] = $signed(s.ptx[i]) + tx;
      r.pty[i] = $signed(s.pty[i]) + ty;
    end
    return r;
  endfunction

  function automatic item_t f_point(input item_t s);
    item_t r;
    r = s;
    if (!s.straight) begin
      r.pos_x = ($signed(s.ptx[0]) + PT_RND) >>> (F - 8);
      r.pos_y = ($signed(s.pty[0]) + PT_RND) >>> (F - 8);
    end
    return r;
  endfunction

  function automatic item_t f_mag(input item_t s);
    item_t r;
    logic [NW-1:0] ax;
    logic [NW-1:0] ay;
    r = s;
    ax = (s.vx < 0) ? NW'(-s.vx) : NW'(s.vx);
    ay = (s.vy < 0) ? NW'(-s.vy) : NW'(s.vy);
    r.m = (ax > ay) ? ax : ay;
    r.zero_vec = (s.vx == '0) && (s.vy == '0);
    return r;
  endfunction

  function automatic item_t f_nr(input item_t s, input int sh);
    item_t r;
    r = s;
    if (s.m >= (NW'(1'b1) << (30 + sh))) begin
      r.m = s.m >> sh;
      r.vx = s.vx >>> sh;
      r.vy = s.vy >>> sh;
    end
    return r;
  endfunction

  function automatic item_t f_nl(input item_t s, input int sh);
    item_t r;
    r = s;
    if (s.m < (NW'(1'b1) << (31 - sh))) begin
      r.m = s.m << sh;
      r.vx = s.vx <<< sh;
      r.vy = s.vy <<< sh;
    end
    return r;
  endfunction

  function automatic item_t f_vpre(input item_t s);
    item_t r;
    r = s;
    r.cx = CW'(s.vx);
    r.cy = CW'(s.vy);
    r.cz = '0;
    if (r.cx < 0) begin
      r.cz = (r.cy >= 0) ? opp_pkg::ANG_180 : -opp_pkg::ANG_180;
      r.cx = -r.cx;
      r.cy = -r.cy;
    end
    return r;
  endfunction

  function automatic item_t f_vec(input item_t s, input int i);
    item_t r;
    r = s;
    if (s.cy > 0) begin
      r.cx = s.cx + (s.cy >>> i);
      r.cy = s.cy - (s.cx >>> i);
      r.cz = s.cz + opp_pkg::atan_ang(i);
    end else begin
      r.cx = s.cx - (s.cy >>> i);
      r.cy = s.cy + (s.cx >>> i);
      r.cz = s.cz - opp_pkg::atan_ang(i);
    end
    return r;
  endfunction

  function automatic item_t f_hdg(input item_t s);
    item_t r;
    logic signed [AW-1:0] z;
    logic signed [AW-1:0] h;
    r = s;
    z = s.cz;
    if (s.zero_vec) begin
      z = '0;
    end else if (z > opp_pkg::ANG_180) begin
      z = opp_pkg::ANG_180;
    end else if (z < -opp_pkg::ANG_180) begin
      z = -opp_pkg::ANG_180;
    end
    h = (z + AW'(4096)) >>> 13;
    if (h > opp_pkg::HEAD_MAX) begin
      h = opp_pkg::HEAD_MAX;
    end else if (h < -opp_pkg::HEAD_MAX) begin
      h = -opp_pkg::HEAD_MAX;
    end
    r.hd = 16'(h);
    r.cx = s.l16;
    r.cy = '0;
    r.cz = z;
    if (z > opp_pkg::ANG_90) begin
      r.cx = -s.l16;
      r.cz = z - opp_pkg::ANG_180;
    end else if (z < -opp_pkg::ANG_90) begin
      r.cx = -s.l16;
      r.cz = z + opp_pkg::ANG_180;
    end
    return r;
  endfunction

  function automatic item_t f_rot(input item_t s, input int i);
    item_t r;
    r = s;
    if (s.cz >= 0) begin
      r.cx = s.cx - (s.cy >>> i);
      r.cy = s.cy + (s.cx >>> i);
      r.cz = s.cz - opp_pkg::atan_ang(i);
    end else begin
      r.cx = s.cx + (s.cy >>> i);
      r.cy = s.cy - (s.cx >>> i);
      r.cz = s.cz + opp_pkg::atan_ang(i);
    end
    return r;
  endfunction

  function automatic opp_pkg::pt_t clamp_pos(input opp_pkg::pt_t v);
    opp_pkg::pt_t r;
    r = v;
    if (v > POS_MAX) begin
      r = POS_MAX;
    end else if (v < POS_MIN) begin
      r = POS_MIN;
    end
    return r;
  endfunction

  function automatic item_t f_out(input item_t s);
    item_t r;
    opp_pkg::pt_t ox;
    opp_pkg::pt_t oy;
    r = s;
    ox = s.pos_x;
    oy = s.pos_y;
    if (s.straight) begin
      ox = (ext_pt(s.sx) <<< 8) + PW'((s.cx + CW'(128)) >>> 8);
      oy = (ext_pt(s.sy) <<< 8) + PW'((s.cy + CW'(128)) >>> 8);
    end
    r.pos_x = clamp_pos(ox);
    r.pos_y = clamp_pos(oy);
    if (!s.ok) begin
      r.pos_x = '0;
      r.pos_y = '0;
      r.hd = '0;
    end
    return r;
  endfunction

  assign busy = 1'b0;

  always_comb begin
    in_item = '0;
    in_item.vld = start && !busy;
    in_item.trav = travelled;
    in_item.straight = is_straight;
    in_item.sx = start_x;
    in_item.sy = start_y;
    in_item.ex = end_x;
    in_item.ey = end_y;
    in_item.c1x = ctrl1_x;
    in_item.c1y = ctrl1_y;
    in_item.c2x = ctrl2_x;
    in_item.c2y = ctrl2_y;
    in_item.len = seg_length;
    in_item.rate = counts_per_unit;
  end

  assign nxt[0] = in_item;
  assign nxt[1] = f_den(pipe[0]);
  assign nxt[2] = f_prep(pipe[1]);

  for (genvar j = 0; j < QW; j++) begin : g_div
    assign nxt[3+j] = f_div(pipe[2+j], QW - 1 - j);
  end

  assign nxt[D_END+1] = f_tsel(pipe[D_END]);
  assign nxt[D_END+2] = f_gain(pipe[D_END+1]);
  assign nxt[D_END+3] = f_l16(pipe[D_END+2]);

  for (genvar l = 0; l < 3; l++) begin : g_lerp
    assign nxt[B0+3*l+1] = f_bsub(pipe[B0+3*l], l == 2);
    assign nxt[B0+3*l+2] = f_bmul(pipe[B0+3*l+1]);
    assign nxt[B0+3*l+3] = f_badd(pipe[B0+3*l+2]);
  end

  assign nxt[P_ST] = f_point(pipe[P_ST-1]);
  assign nxt[M_ST] = f_mag(pipe[P_ST]);

  for (genvar j = 0; j < 5; j++) begin : g_norm
    assign nxt[M_ST+1+j] = f_nr(pipe[M_ST+j], 16 >> j);
    assign nxt[M_ST+6+j] = f_nl(pipe[M_ST+5+j], 16 >> j);
  end

  assign nxt[V0] = f_vpre(pipe[V0-1]);

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    assign nxt[V0+1+i] = f_vec(pipe[V0+i], i);
    assign nxt[H_ST+1+i] = f_rot(pipe[H_ST+i], i);
  end

  assign nxt[H_ST] = f_hdg(pipe[H_ST-1]);
  assign nxt[LAST] = f_out(pipe[LAST-1]);

  always_ff @(posedge clk) begin
    for (int k = 0; k <= LAST; k++) begin
      pipe[k] <= rst ? f_clr(nxt[k]) : nxt[k];
    end
  end

  assign done      = pipe[LAST].vld;
  assign valid_res = pipe[LAST].ok;
  assign pos_x     = pipe[LAST].pos_x[27:0];
  assign pos_y     = pipe[LAST].pos_y[27:0];
  assign heading   = pipe[LAST].hd;

endmodule

// File: hw/rtl/opp_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometer path pose checker
// Port-level assertions on beat timing and result fields, bound to the top.
// ----------------------------------------------------------------------------
module opp_check #(
  parameter int CORDIC_STEPS = opp_pkg::CORDIC_STEPS_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic               valid_res,
  input logic signed [27:0] pos_x,
  input logic signed [27:0] pos_y,
  input logic signed [15:0] heading
);

  localparam int LAT = opp_pkg::pipe_last(CORDIC_STEPS) + 1;

  a_issue_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("An accepted beat did not produce a result in time.");

  a_done_has_issue: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("A result beat appeared without a matching input beat.");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !valid_res) |-> (pos_x == '0 && pos_y == '0 && heading == '0))
    else $error("An invalid result carries nonzero fields.");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ($signed(heading) <= 16'sd23040 && $signed(heading) >= -16'sd23040))
    else $error("Heading is outside the half-turn range.");

endmodule

bind odometer_path_pose_unit opp_check #(.CORDIC_STEPS(CORDIC_STEPS)) u_opp_check (.*);

// File: dv/tb_odometer_path_pose_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometer path pose unit testbench
// Drives straight and Bezier segment beats through the pose unit with random
// gaps and checks every pose beat against a cycle-free fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_odometer_path_pose_unit;

  localparam int  STEPS   = opp_pkg::CORDIC_STEPS_DEF;
  localparam int  CB      = opp_pkg::COORD_BITS_DEF;
  localparam int  FRAC    = 44 - CB;
  localparam int  LATENCY = 62 + 2 * STEPS;
  localparam longint A180 = 188743680;
  localparam longint A90  = 94371840;
  localparam longint GAIN = 652032874;

  typedef struct {
    logic signed [23:0]   trav;
    logic                 straight;
    logic signed [CB-1:0] sx, sy, ex, ey, c1x, c1y, c2x, c2y;
    logic [19:0]          len;
    logic [15:0]          rate;
  } seg_beat_t;

  typedef struct {
    logic               ok;
    logic signed [27:0] px, py;
    logic signed [15:0] hd;
  } pose_t;

  logic clk, rst, start, busy, done;
  logic valid_res;
  logic signed [27:0] pos_x, pos_y;
  logic signed [15:0] heading;
  seg_beat_t drv;
  pose_t pending_poses[$];
  int mismatches, beats_sent, poses_seen, straight_sent, curve_sent;

  odometer_path_pose_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .travelled(drv.trav), .is_straight(drv.straight),
    .start_x(drv.sx), .start_y(drv.sy), .end_x(drv.ex), .end_y(drv.ey),
    .ctrl1_x(drv.c1x), .ctrl1_y(drv.c1y), .ctrl2_x(drv.c2x), .ctrl2_y(drv.c2y),
    .seg_length(drv.len), .counts_per_unit(drv.rate),
    .done(done), .valid_res(valid_res), .pos_x(pos_x), .pos_y(pos_y),
    .heading(heading)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint vector_angle(longint x, longint y);
    longint z, m, nx, ny;
    z = 0;
    if (x == 0 && y == 0) return 0;
    m = mag(x) > mag(y) ? mag(x) : mag(y);
    while (m >= 64'sd2147483648) begin
      x = x >>> 1;
      y = y >>> 1;
      m = m >>> 1;
    end
    while (m < 64'sd1073741824) begin
      x = x * 2;
      y = y * 2;
      m = m * 2;
    end
    if (x < 0) begin
      z = (y >= 0) ? A180 : -A180;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += longint'(opp_pkg::atan_ang(i));
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= longint'(opp_pkg::atan_ang(i));
      end
      x = nx;
      y = ny;
    end
    return clip(z, -A180, A180);
  endfunction

  task automatic rotate_length(input longint len, input longint z,
                               output longint ox, output longint oy);
    longint x, y, nx, ny;
    x = len;
    y = 0;
    if (z > A90) begin
      x = -x; z -= A180;
    end else if (z < -A90) begin
      x = -x; z += A180;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= longint'(opp_pkg::atan_ang(i));
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += longint'(opp_pkg::atan_ang(i));
      end
      x = nx;
      y = ny;
    end
    ox = x;
    oy = y;
  endtask

  function automatic longint blend(longint a, longint b, longint t);
    return a + (((b - a) * t + 32768) >>> 16);
  endfunction

  task automatic predict_pose(input seg_beat_t s, output pose_t p);
    longint trav, len, rate, px, py, z, d, l16, rx, ry, den, t, one;
    longint q0x, q0y, q1x, q1y, q2x, q2y, r0x, r0y, r1x, r1y;
    trav = s.trav;
    len = s.len;
    rate = s.rate;
    p = '{1'b0, '0, '0, '0};
    if (rate == 0 || len == 0 || trav == 0 || trav > len * rate) return;
    if (s.straight) begin
      d = (mag(trav) * 256 + rate / 2) / rate;
      if (trav < 0) d = -d;
      l16 = (d * GAIN + (64'sd1 << 21)) >>> 22;
      z = vector_angle(longint'(s.ex) - s.sx, longint'(s.ey) - s.sy);
      rotate_length(l16, z, rx, ry);
      px = longint'(s.sx) * 256 + ((rx + 128) >>> 8);
      py = longint'(s.sy) * 256 + ((ry + 128) >>> 8);
    end else begin
      den = len * rate;
      one = 64'sd1 << FRAC;
      t = 0;
      if (trav > 0) t = (trav * 65536 + den / 2) / den;
      t = clip(t, 0, 65536);
      q0x = blend(s.sx * one, s.c1x * one, t);  q0y = blend(s.sy * one, s.c1y * one, t);
      q1x = blend(s.c1x * one, s.c2x * one, t); q1y = blend(s.c1y * one, s.c2y * one, t);
      q2x = blend(s.c2x * one, s.ex * one, t);  q2y = blend(s.c2y * one, s.ey * one, t);
      r0x = blend(q0x, q1x, t); r0y = blend(q0y, q1y, t);
      r1x = blend(q1x, q2x, t); r1y = blend(q1y, q2y, t);
      px = (blend(r0x, r1x, t) + (64'sd1 << (FRAC - 9))) >>> (FRAC - 8);
      py = (blend(r0y, r1y, t) + (64'sd1 << (FRAC - 9))) >>> (FRAC - 8);
      z = vector_angle(r1x - r0x, r1y - r0y);
    end
    p.ok = 1'b1;
    p.px = 28'(clip(px, -134217728, 134217727));
    p.py = 28'(clip(py, -134217728, 134217727));
    p.hd = 16'(clip((z + 4096) >>> 13, -23040, 23040));
  endtask

  // Holds start high through back-to-back beats; a gap lowers it first.
  task automatic send_beat(input seg_beat_t s, input int gap);
    pose_t p;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    drv <= s;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predict_pose(s, p);
    pending_poses = {pending_poses, p};
    beats_sent++;
    if (s.straight) straight_sent++; else curve_sent++;
    @(negedge clk);
  endtask

  function automatic seg_beat_t random_beat(input logic straight, input logic in_range);
    seg_beat_t s;
    longint reach;
    s.straight = straight;
    s.sx = CB'($urandom()); s.sy = CB'($urandom());
    s.ex = CB'($urandom()); s.ey = CB'($urandom());
    s.c1x = CB'($urandom()); s.c1y = CB'($urandom());
    s.c2x = CB'($urandom()); s.c2y = CB'($urandom());
    s.len = 20'(($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(1, 4000));
    s.rate = 16'(($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(1, 300));
    s.trav = 24'($urandom());
    if (in_range) begin
      if (s.len == 0) s.len = 1;
      if (s.rate == 0) s.rate = 1;
      reach = clip(longint'(s.len) * s.rate, 1, 8388607);
      s.trav = 24'($urandom_range(0, 7) == 0 ? -$urandom_range(1, 8388608)
                                              : $urandom_range(1, int'(reach)));
    end
    return s;
  endfunction

  task automatic test_directed_cases();
    seg_beat_t s;
    s = '{24'sd1000, 1'b1, '0, '0, 20'sd100, 20'sd100, '0, '0, '0, '0, 20'd200, 16'd10};
    send_beat(s, 0);
    s.sx = 20'sh80000; s.sy = 20'sh7FFFF; s.ex = 20'sh7FFFF; s.ey = 20'sh80000;
    send_beat(s, 0);
    s.ex = s.sx; s.ey = s.sy;
    send_beat(s, 1);
    s.trav = 24'sh800000;
    send_beat(s, 0);
    s.trav = 24'sh7FFFFF; s.len = 20'hFFFFF; s.rate = 16'hFFFF;
    send_beat(s, 0);
    s.trav = 24'sd0;
    send_beat(s, 2);
    s.trav = 24'sd5; s.rate = '0;
    send_beat(s, 0);
    s.rate = 16'd1; s.len = '0;
    send_beat(s, 0);
    s.len = 20'd4; s.trav = 24'sd5;
    send_beat(s, 0);
    s.trav = 24'sd4;
    send_beat(s, 0);
    s = '{24'sd1, 1'b0, 20'sh80000, 20'sh80000, 20'sh7FFFF, 20'sh7FFFF,
          20'sh7FFFF, 20'sh80000, 20'sh80000, 20'sh7FFFF, 20'd1, 16'd1};
    send_beat(s, 0);
    s.trav = 24'sd1; s.len = 20'hFFFFF; s.rate = 16'hFFFF;
    send_beat(s, 3);
    s.trav = 24'sh7FFFFF;
    send_beat(s, 0);
    s.trav = -24'sd77; s.len = 20'd100; s.rate = 16'd3;
    send_beat(s, 0);
    s.trav = 24'sd150;
    send_beat(s, 0);
    s = '{24'sd50, 1'b0, '0, '0, '0, '0, '0, '0, '0, '0, 20'd100, 16'd1};
    send_beat(s, 0);
  endtask

  task automatic test_random_straight(input int n);
    repeat (n) send_beat(random_beat(1'b1, $urandom_range(0, 9) != 0), $urandom_range(0, 7));
  endtask

  task automatic test_random_curve(input int n);
    repeat (n) send_beat(random_beat(1'b0, $urandom_range(0, 9) != 0), $urandom_range(0, 7));
  endtask

  task automatic test_back_to_back(input int n);
    repeat (n) send_beat(random_beat(1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0), 0);
  endtask

  always @(posedge clk) begin
    pose_t e;
    if (!rst && done) begin
      poses_seen++;
      if (pending_poses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pose beat at %0t", $realtime);
      end else begin
        e = pending_poses.pop_front();
        if (valid_res !== e.ok || pos_x !== e.px || pos_y !== e.py || heading !== e.hd) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pose mismatch: exp v=%0b x=%0d y=%0d h=%0d got v=%0b x=%0d y=%0d h=%0d",
                     e.ok, e.px, e.py, e.hd, valid_res, pos_x, pos_y, heading);
        end
      end
    end
  end

  initial begin
    int waited;
    mismatches = 0; beats_sent = 0; poses_seen = 0; straight_sent = 0; curve_sent = 0;
    start = 1'b0;
    drv = '{'0, 1'b0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0};
    rst = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed_cases();
    test_random_straight(300);
    test_random_curve(300);
    test_back_to_back(230);
    start <= 1'b0;
    waited = 0;
    while (pending_poses.size() != 0 && waited < 20 * LATENCY) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (pending_poses.size() != 0) begin
      mismatches++;
      $display("%0d pose beats never arrived", pending_poses.size());
    end
    $display("Sent %0d segment beats (%0d straight, %0d curve), checked %0d pose beats.",
             beats_sent, straight_sent, curve_sent, poses_seen);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
